>>> src/tle_pkg.sv
// Package for the terminal line editor: character codes, result kinds,
// the per-item response descriptor and default sizes. No dependencies.
package tle_pkg;

	localparam int LINE_DEPTH_DEF = 64;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam logic [1:0] KIND_ECHO      = 2'd0;
	localparam logic [1:0] KIND_DATA      = 2'd1;
	localparam logic [1:0] KIND_NOT_READY = 2'd2;
	localparam logic [1:0] KIND_REFUSED   = 2'd3;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_EOL,
		OP_ERASE,
		OP_REFUSED,
		OP_NOT_READY,
		OP_READ
	} resp_op_t;

	typedef struct packed {
		resp_op_t   op;
		logic [7:0] ch;
		logic       line_end;
	} resp_desc_t;

endpackage

>>> src/tle_line_ram.sv
// Line store: single-port-write, single-port-read synchronous memory with
// a registered read. Depends on nothing.
module tle_line_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata_q
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

>>> src/tle_ctrl.sv
// Editing control: decodes each accepted transaction, updates the fill count,
// read position and mode, drives the line store ports. Depends on tle_pkg.
module tle_ctrl #(
	parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF,
	parameter int ADDR_W     = $clog2(LINE_DEPTH),
	parameter int CNT_W      = $clog2(LINE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_action,
	input  logic [7:0]           in_byte,
	output logic                 mem_we,
	output logic [ADDR_W-1:0]    mem_waddr,
	output logic [7:0]           mem_wdata,
	output logic                 mem_re,
	output logic [ADDR_W-1:0]    mem_raddr,
	output logic                 valid_s1,
	output tle_pkg::resp_desc_t  desc_s1,
	input  logic                 take_s1
);

	import tle_pkg::*;

	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] rdpos_q;
	logic              collecting_q;

	logic              accept;
	logic              is_eol;
	logic              is_erase;
	logic              has_resp;
	resp_desc_t        desc_d;
	logic [CNT_W-1:0]  fill_d;
	logic [ADDR_W-1:0] rdpos_d;
	logic              collecting_d;
	logic [CNT_W-1:0]  rdpos_next;

	assign in_ready   = !valid_s1 || take_s1;
	assign accept     = in_valid && in_ready;
	assign is_eol     = (in_byte == CH_LF) || (in_byte == CH_CR);
	assign is_erase   = (in_byte == CH_BS) || (in_byte == CH_DEL);
	assign rdpos_next = CNT_W'(rdpos_q) + CNT_W'(1);

	assign mem_waddr = fill_q[ADDR_W-1:0];
	assign mem_raddr = rdpos_q;

	// A read never meets a write in the same cycle, and the closing write lands
	// before the first read can be issued, so no forwarding is needed.
	always_comb begin
		has_resp      = 1'b0;
		desc_d.op     = OP_CHAR;
		desc_d.ch     = in_byte;
		desc_d.line_end = 1'b0;
		fill_d        = fill_q;
		rdpos_d       = rdpos_q;
		collecting_d  = collecting_q;
		mem_we        = 1'b0;
		mem_wdata     = in_byte;
		mem_re        = 1'b0;
		if (accept) begin
			if (!in_action) begin
				if (!collecting_q) begin
					has_resp  = 1'b1;
					desc_d.op = OP_REFUSED;
				end else if (!is_eol && fill_q >= CNT_W'(LINE_DEPTH - 1)) begin
					has_resp = 1'b0;
				end else if (is_erase) begin
					if (fill_q != '0) begin
						has_resp  = 1'b1;
						desc_d.op = OP_ERASE;
						fill_d    = fill_q - CNT_W'(1);
					end
				end else if (is_eol) begin
					has_resp     = 1'b1;
					desc_d.op    = OP_EOL;
					mem_we       = 1'b1;
					mem_wdata    = CH_LF;
					fill_d       = fill_q + CNT_W'(1);
					collecting_d = 1'b0;
					rdpos_d      = '0;
				end else begin
					has_resp  = 1'b1;
					desc_d.op = OP_CHAR;
					mem_we    = 1'b1;
					fill_d    = fill_q + CNT_W'(1);
				end
			end else if (collecting_q) begin
				has_resp  = 1'b1;
				desc_d.op = OP_NOT_READY;
			end else begin
				has_resp  = 1'b1;
				desc_d.op = OP_READ;
				mem_re    = 1'b1;
				if (rdpos_next >= fill_q) begin
					desc_d.line_end = 1'b1;
					rdpos_d         = '0;
					fill_d          = '0;
					collecting_d    = 1'b1;
				end else begin
					rdpos_d = rdpos_next[ADDR_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			rdpos_q      <= '0;
			collecting_q <= 1'b1;
			valid_s1     <= 1'b0;
		end else begin
			fill_q       <= fill_d;
			rdpos_q      <= rdpos_d;
			collecting_q <= collecting_d;
			if (accept) begin
				valid_s1 <= has_resp;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

>>> src/tle_emit.sv
// Result sequencer: expands one response descriptor into its one to three
// result transactions behind an output register. Depends on tle_pkg.
module tle_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tle_pkg::resp_desc_t in_desc,
	input  logic [7:0]          in_rdata,
	output logic                in_take,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_kind,
	output logic [7:0]          out_data,
	output logic                out_last
);

	import tle_pkg::*;

	resp_op_t   op_q;
	logic [7:0] data_q;
	logic       end_q;
	logic [1:0] step_q;
	logic       valid_q;
	logic       final_step;
	logic       done;

	assign out_valid = valid_q;
	assign done      = valid_q && out_ready && final_step;
	assign in_take   = in_valid && (!valid_q || done);

	always_comb begin
		out_kind   = KIND_ECHO;
		out_data   = 8'h00;
		out_last   = 1'b1;
		final_step = 1'b1;
		unique case (op_q)
			OP_CHAR: begin
				out_data = data_q;
			end
			OP_EOL: begin
				final_step = (step_q == 2'd1);
				out_last   = final_step;
				out_data   = final_step ? CH_LF : CH_CR;
			end
			OP_ERASE: begin
				final_step = (step_q == 2'd2);
				out_last   = final_step;
				out_data   = (step_q == 2'd1) ? CH_SP : CH_BS;
			end
			OP_REFUSED: begin
				out_kind = KIND_REFUSED;
			end
			OP_NOT_READY: begin
				out_kind = KIND_NOT_READY;
			end
			OP_READ: begin
				out_kind = KIND_DATA;
				out_data = data_q;
				out_last = end_q;
			end
			default: begin
				out_kind = KIND_ECHO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else if (in_take) begin
			valid_q <= 1'b1;
			step_q  <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else if (valid_q && out_ready) begin
			step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q   <= in_desc.op;
			end_q  <= in_desc.line_end;
			data_q <= (in_desc.op == OP_READ) ? in_rdata : in_desc.ch;
		end
	end

endmodule

>>> src/terminal_line_editor.sv
// Terminal line editor top level: control stage, line store memory and
// result sequencer. Depends on tle_pkg, tle_ctrl, tle_line_ram, tle_emit.
//
// The slave channel carries one transaction per received byte or read
// request: tuser is the action (0 byte from the link, 1 reader request) and
// tdata the received byte. The master channel carries results: tuser is the
// kind (echo, read data, not ready, refused), tdata the character and tlast
// marks the final result of a transaction, or for read data the end of line.
// A received byte gives at most three echo results; the result sequencer
// sets the sustained pace at one result per cycle while the receiver is
// ready. After acceptance, a transaction passes the control stage, where
// the line store is read or written, and then the output register before
// its first result appears. Input is accepted while earlier results
// drain, as long as the control stage can hand its transaction to the
// sequencer. When the receiver stalls, results hold and the input channel
// stops after one more transaction that has results; bytes that are
// dropped without a result are still taken. Reset empties the line and
// starts collecting; the store contents are not cleared.
module terminal_line_editor #(
	parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
	input  logic       s_axis_tuser,  // [0] action
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] data
	output logic [1:0] m_axis_tuser,  // [1:0] kind
	output logic       m_axis_tlast
);

	import tle_pkg::*;

	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam int CNT_W  = $clog2(LINE_DEPTH + 1);

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_rdata;
	logic              valid_s1;
	resp_desc_t        desc_s1;
	logic              take_s1;

	tle_ctrl #(
		.LINE_DEPTH(LINE_DEPTH),
		.ADDR_W    (ADDR_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_action(s_axis_tuser),
		.in_byte  (s_axis_tdata),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.valid_s1 (valid_s1),
		.desc_s1  (desc_s1),
		.take_s1  (take_s1)
	);

	tle_line_ram #(
		.DEPTH (LINE_DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata_q(mem_rdata)
	);

	tle_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_desc  (desc_s1),
		.in_rdata (mem_rdata),
		.in_take  (take_s1),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_kind (m_axis_tuser),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule
